[hdl/cmdp_pkg.sv]
// Shared types, constants and the CRC-8 byte update for the command frame parser.
package cmdp_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        REG_DEVICE_ADDRESS = 2'd0,
        REG_PREFIX_BYTE    = 2'd1,
        REG_CRC_POLY       = 2'd2,
        REG_CRC_REFLECTED  = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_ADDRESS = 2'd1,
        PH_COMMAND = 2'd2,
        PH_CRC     = 2'd3
    } phase_t;

    // Configuration as seen by the parser core.
    typedef struct packed {
        byte_t device_address;
        byte_t prefix_byte;
        byte_t crc_poly;
        logic  crc_reflected;
        byte_t prefix_crc;
        logic  settled;
    } cfg_t;

    // One CRC-8 byte update: XOR the byte in, then eight shifts.
    function automatic byte_t crc_feed(byte_t data, byte_t init, byte_t poly, logic refl);
        byte_t v;
        v = data ^ init;
        for (int i = 0; i < BYTE_W; i++) begin
            if (refl) begin
                v = v[0] ? ((v >> 1) ^ poly) : (v >> 1);
            end else begin
                v = v[BYTE_W-1] ? ((v << 1) ^ poly) : (v << 1);
            end
        end
        return v;
    endfunction

endpackage

[hdl/crc_checked_command_frame_parser.sv]
// Top level of the CRC-8 checked command frame parser: input register and submodules.
//
//  channel   direction  handshake                 payload
//  rx        in         rx_valid / rx_ready       rx_byte
//  result    out        out_valid / out_ready     frame_accepted, command_code
//  config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// Each request byte passes through the input register, then through the CRC update
// into the result register; one byte a cycle while results are taken and the
// configuration has settled. Every byte yields exactly one result; a full result
// register that is not taken stalls the byte behind it, and the input register then
// holds rx_ready low. Reset is asynchronous and active low and, like a configuration
// write, is followed by a hold-off on bytes while the prefix CRC settles.
module crc_checked_command_frame_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        frame_accepted,
    output logic [7:0]                  command_code,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmdp_pkg::ADDR_W-1:0] paddr,
    input  logic [cmdp_pkg::DATA_W-1:0] pwdata,
    output logic [cmdp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    cmdp_pkg::cfg_t  cfg;
    logic            in_valid_reg;
    cmdp_pkg::byte_t in_byte_reg;
    logic            fire;

    assign rx_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (rx_ready) begin
            in_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (rx_ready && rx_valid) begin
            in_byte_reg <= rx_byte;
        end
    end

    cmdp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cmdp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .byte_valid     (in_valid_reg),
        .byte_in        (in_byte_reg),
        .fire           (fire),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_accepted (frame_accepted),
        .command_code   (command_code)
    );

endmodule

[hdl/cmdp_cfg.sv]
// Configuration registers, APB-style access and the precomputed CRC of the prefix.
module cmdp_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cmdp_pkg::ADDR_W-1:0] paddr,
    input  logic [cmdp_pkg::DATA_W-1:0] pwdata,
    output logic [cmdp_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output cmdp_pkg::cfg_t              cfg
);

    cmdp_pkg::byte_t device_address_reg;
    cmdp_pkg::byte_t prefix_byte_reg;
    cmdp_pkg::byte_t crc_poly_reg;
    logic            crc_reflected_reg;
    cmdp_pkg::byte_t prefix_crc_reg;
    logic [1:0]      settle_reg;
    logic [1:0]      settle_next;
    logic            wr_en;
    cmdp_pkg::reg_index_t index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = cmdp_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            device_address_reg <= 8'd1;
            prefix_byte_reg    <= 8'd49;
            crc_poly_reg       <= 8'd140;
            crc_reflected_reg  <= 1'b1;
        end else if (wr_en) begin
            case (index)
                cmdp_pkg::REG_DEVICE_ADDRESS: device_address_reg <= pwdata[7:0];
                cmdp_pkg::REG_PREFIX_BYTE:    prefix_byte_reg    <= pwdata[7:0];
                cmdp_pkg::REG_CRC_POLY:       crc_poly_reg       <= pwdata[7:0];
                cmdp_pkg::REG_CRC_REFLECTED:  crc_reflected_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // The prefix CRC is registered from the configuration registers and the core's held
    // command CRC from the prefix CRC, so the core is held off after any write.
    always_comb begin
        if (wr_en) begin
            settle_next = 2'd2;
        end else if (settle_reg != 2'd0) begin
            settle_next = settle_reg - 2'd1;
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            settle_reg     <= 2'd2;
            prefix_crc_reg <= '0;
        end else begin
            settle_reg     <= settle_next;
            prefix_crc_reg <= cmdp_pkg::crc_feed(prefix_byte_reg, 8'd0, crc_poly_reg,
                                                 crc_reflected_reg);
        end
    end

    always_comb begin
        case (index)
            cmdp_pkg::REG_DEVICE_ADDRESS: prdata = {24'd0, device_address_reg};
            cmdp_pkg::REG_PREFIX_BYTE:    prdata = {24'd0, prefix_byte_reg};
            cmdp_pkg::REG_CRC_POLY:       prdata = {24'd0, crc_poly_reg};
            cmdp_pkg::REG_CRC_REFLECTED:  prdata = {31'd0, crc_reflected_reg};
            default:                      prdata = '0;
        endcase
    end

    assign cfg.device_address = device_address_reg;
    assign cfg.prefix_byte    = prefix_byte_reg;
    assign cfg.crc_poly       = crc_poly_reg;
    assign cfg.crc_reflected  = crc_reflected_reg;
    assign cfg.prefix_crc     = prefix_crc_reg;
    assign cfg.settled        = (settle_reg == 2'd0);

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |=> !cfg.settled)
        else $error("core not held off after a configuration write");

endmodule

[hdl/cmdp_core.sv]
// Frame parser state, resynchronization and the result register.
module cmdp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  cmdp_pkg::cfg_t   cfg,
    input  logic             byte_valid,
    input  cmdp_pkg::byte_t  byte_in,
    output logic             fire,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             frame_accepted,
    output cmdp_pkg::byte_t  command_code
);

    cmdp_pkg::phase_t phase_reg;
    cmdp_pkg::phase_t phase_next;
    cmdp_pkg::byte_t  running_crc_reg;
    cmdp_pkg::byte_t  running_crc_next;
    cmdp_pkg::byte_t  held_address_reg;
    cmdp_pkg::byte_t  held_address_next;
    cmdp_pkg::byte_t  held_command_reg;
    cmdp_pkg::byte_t  held_command_next;
    // CRC of prefix then held command, ready for a restart at the address slot.
    cmdp_pkg::byte_t  alt_crc_reg;
    logic             out_valid_reg;
    logic             frame_accepted_reg;
    cmdp_pkg::byte_t  command_code_reg;

    cmdp_pkg::byte_t  feed_run;
    cmdp_pkg::byte_t  feed_pre;
    cmdp_pkg::byte_t  feed_alt;
    logic             is_prefix;
    logic             crc_match;
    logic             addr_slot_prefix;
    logic             cmd_slot_prefix;
    logic             ok;

    assign fire = byte_valid && cfg.settled && (!out_valid_reg || out_ready);

    assign feed_run = cmdp_pkg::crc_feed(byte_in, running_crc_reg, cfg.crc_poly,
                                         cfg.crc_reflected);
    assign feed_pre = cmdp_pkg::crc_feed(byte_in, cfg.prefix_crc, cfg.crc_poly,
                                         cfg.crc_reflected);
    assign feed_alt = cmdp_pkg::crc_feed(byte_in, alt_crc_reg, cfg.crc_poly,
                                         cfg.crc_reflected);

    assign is_prefix        = (byte_in == cfg.prefix_byte);
    assign crc_match        = (byte_in == running_crc_reg);
    assign addr_slot_prefix = (held_address_reg == cfg.prefix_byte);
    assign cmd_slot_prefix  = (held_command_reg == cfg.prefix_byte);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            case (phase_reg)
                cmdp_pkg::PH_PREFIX:
                    phase_next = is_prefix ? cmdp_pkg::PH_ADDRESS : cmdp_pkg::PH_PREFIX;
                cmdp_pkg::PH_ADDRESS: phase_next = cmdp_pkg::PH_COMMAND;
                cmdp_pkg::PH_COMMAND: phase_next = cmdp_pkg::PH_CRC;
                cmdp_pkg::PH_CRC: begin
                    if (crc_match) begin
                        phase_next = cmdp_pkg::PH_PREFIX;
                    end else if (addr_slot_prefix) begin
                        phase_next = cmdp_pkg::PH_CRC;
                    end else if (cmd_slot_prefix) begin
                        phase_next = cmdp_pkg::PH_COMMAND;
                    end else begin
                        phase_next = is_prefix ? cmdp_pkg::PH_ADDRESS : cmdp_pkg::PH_PREFIX;
                    end
                end
                default: phase_next = cmdp_pkg::PH_PREFIX;
            endcase
        end
    end

    // Frame data and result.
    always_comb begin
        running_crc_next  = running_crc_reg;
        held_address_next = held_address_reg;
        held_command_next = held_command_reg;
        ok                = 1'b0;
        if (fire) begin
            case (phase_reg)
                cmdp_pkg::PH_PREFIX:
                    running_crc_next = is_prefix ? cfg.prefix_crc : 8'd0;
                cmdp_pkg::PH_ADDRESS: begin
                    held_address_next = byte_in;
                    running_crc_next  = feed_run;
                end
                cmdp_pkg::PH_COMMAND: begin
                    held_command_next = byte_in;
                    running_crc_next  = feed_run;
                end
                cmdp_pkg::PH_CRC: begin
                    if (crc_match) begin
                        ok               = (held_address_reg == cfg.device_address);
                        running_crc_next = 8'd0;
                    end else if (addr_slot_prefix) begin
                        held_address_next = held_command_reg;
                        held_command_next = byte_in;
                        running_crc_next  = feed_alt;
                    end else if (cmd_slot_prefix) begin
                        held_address_next = byte_in;
                        running_crc_next  = feed_pre;
                    end else begin
                        running_crc_next = is_prefix ? cfg.prefix_crc : 8'd0;
                    end
                end
                default: running_crc_next = 8'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg        <= cmdp_pkg::PH_PREFIX;
            running_crc_reg  <= '0;
            held_address_reg <= '0;
            held_command_reg <= '0;
            alt_crc_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            phase_reg        <= phase_next;
            running_crc_reg  <= running_crc_next;
            held_address_reg <= held_address_next;
            held_command_reg <= held_command_next;
            alt_crc_reg      <= cmdp_pkg::crc_feed(held_command_next, cfg.prefix_crc,
                                                   cfg.crc_poly, cfg.crc_reflected);
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (fire) begin
            frame_accepted_reg <= ok;
            command_code_reg   <= ok ? held_command_reg : 8'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_accepted = frame_accepted_reg;
    assign command_code   = command_code_reg;

    assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_reg)
        else $error("processed byte produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ok) |=> (phase_reg == cmdp_pkg::PH_PREFIX && running_crc_reg == 8'd0))
        else $error("parser did not restart after an accepted frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !frame_accepted_reg) |-> (command_code_reg == 8'd0))
        else $error("command code set without an accepted frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(command_code_reg)))
        else $error("stalled result changed");

endmodule
